// File: sv/shr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics recurrence package
// Shared widths, payload types, fixed-point constants and the reciprocal table.
// ----------------------------------------------------------------------------
package shr_pkg;

  localparam int unsigned DEG_MAX     = 7;
  localparam int unsigned DEG_RESET   = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned R2_W    = 34;
  localparam int unsigned VAL_W   = 48;
  localparam int unsigned A_W     = 36;  // multiplier operand a (coord, r2, reciprocal)
  localparam int unsigned V_W     = 54;  // multiplier operand v (value or partial sum)
  localparam int unsigned R_W     = 56;  // rounded product
  localparam int unsigned FRAC    = 30;
  localparam int unsigned RCP_W   = 31;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VAL_W-1:0]   val_t;

  localparam val_t ONE_Q45 = 48'sh2000_0000_0000;
  localparam val_t VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam val_t VAL_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic [R2_W-1:0]   r2;
    logic [2:0]        top;
  } pt_t;

  typedef struct packed {
    logic                  start;
    logic signed [A_W-1:0] a;
    logic signed [V_W-1:0] v;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [R_W-1:0] res;
  } mul_rsp_t;

  localparam int unsigned RECIP_COUNT = 50;
  localparam int unsigned Q30 = 1073741824;

  // round(2^30 / k)
  localparam int unsigned RECIP_TAB [RECIP_COUNT] = '{
    0,
    (Q30 + 0) / 1,   (Q30 + 1) / 2,   (Q30 + 1) / 3,   (Q30 + 2) / 4,   (Q30 + 2) / 5,
    (Q30 + 3) / 6,   (Q30 + 3) / 7,   (Q30 + 4) / 8,   (Q30 + 4) / 9,   (Q30 + 5) / 10,
    (Q30 + 5) / 11,  (Q30 + 6) / 12,  (Q30 + 6) / 13,  (Q30 + 7) / 14,  (Q30 + 7) / 15,
    (Q30 + 8) / 16,  (Q30 + 8) / 17,  (Q30 + 9) / 18,  (Q30 + 9) / 19,  (Q30 + 10) / 20,
    (Q30 + 10) / 21, (Q30 + 11) / 22, (Q30 + 11) / 23, (Q30 + 12) / 24, (Q30 + 12) / 25,
    (Q30 + 13) / 26, (Q30 + 13) / 27, (Q30 + 14) / 28, (Q30 + 14) / 29, (Q30 + 15) / 30,
    (Q30 + 15) / 31, (Q30 + 16) / 32, (Q30 + 16) / 33, (Q30 + 17) / 34, (Q30 + 17) / 35,
    (Q30 + 18) / 36, (Q30 + 18) / 37, (Q30 + 19) / 38, (Q30 + 19) / 39, (Q30 + 20) / 40,
    (Q30 + 20) / 41, (Q30 + 21) / 42, (Q30 + 21) / 43, (Q30 + 22) / 44, (Q30 + 22) / 45,
    (Q30 + 23) / 46, (Q30 + 23) / 47, (Q30 + 24) / 48, (Q30 + 24) / 49
  };

  function automatic logic [RCP_W-1:0] recip(input logic [5:0] k);
    logic [31:0] e;
    e = 32'(RECIP_TAB[k]);
    recip = (k < 6'(RECIP_COUNT)) ? e[RCP_W-1:0] : '0;
  endfunction

  function automatic val_t sat_val(input logic signed [R_W-1:0] v);
    if ((&v[R_W-1:VAL_W-1]) || (~|v[R_W-1:VAL_W-1])) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[R_W-1]) begin
      sat_val = VAL_MIN;
    end else begin
      sat_val = VAL_MAX;
    end
  endfunction

endpackage

// File: sv/shr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics channel interfaces
// Point input channel and harmonic result channel, valid/ready.
// ----------------------------------------------------------------------------
interface shr_point_if import shr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

interface shr_result_if import shr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       degree;
  logic signed [3:0] order;
  val_t             harmonic_value;
  logic             last;

  modport source (output valid, output degree, output order, output harmonic_value,
                  output last, input ready);
  modport sink   (input valid, input degree, input order, input harmonic_value,
                  input last, output ready);
endinterface

// File: sv/shr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics front end
// Accepts a point, forms r squared from the three squared coordinates, clamps
// the degree and pushes the job into the queue.
// ----------------------------------------------------------------------------
module shr_front import shr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = DEG_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shr_point_if.sink   point_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output pt_t         push_data_o
);

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} state_e;

  localparam logic [2:0] MaxDeg = 3'(MAX_DEGREE);

  state_e      state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  max_deg_q;
  coord_t      x_q, y_q, z_q;
  logic [2:0]  top_q;
  logic [63:0] sq_q, sq_rnd;
  coord_t      sq_op;
  logic signed [63:0] sq_prod;
  logic        accept;

  assign point_i.ready = (state_q == F_IDLE);
  assign accept        = point_i.valid && point_i.ready;

  always_comb begin
    case (cnt_q)
      2'd0:    sq_op = x_q;
      2'd1:    sq_op = y_q;
      default: sq_op = z_q;
    endcase
  end

  assign sq_prod = sq_op * sq_op;
  assign sq_rnd  = sq_q + 64'h2000_0000;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: if (accept) begin
        state_d = F_SQ;
        cnt_d   = 2'd0;
      end
      F_SQ: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) state_d = F_PUSH;
      end
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      cnt_q     <= 2'd0;
      max_deg_q <= 3'(DEG_RESET);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) max_deg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= point_i.coord_x;
      y_q   <= point_i.coord_y;
      z_q   <= point_i.coord_z;
      top_q <= (max_deg_q > MaxDeg) ? MaxDeg : max_deg_q;
      sq_q  <= '0;
    end else if (state_q == F_SQ) begin
      sq_q <= sq_q + $unsigned(sq_prod);
    end
  end

  assign push_valid_o    = (state_q == F_PUSH);
  assign push_data_o.x   = x_q;
  assign push_data_o.y   = y_q;
  assign push_data_o.z   = z_q;
  assign push_data_o.r2  = sq_rnd[FRAC+R2_W-1:FRAC];
  assign push_data_o.top = top_q;

endmodule

// File: sv/shr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics job queue
// Short queue of classified points between front end and sequencer.
// ----------------------------------------------------------------------------
module shr_fifo import shr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  pt_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output pt_t  pop_data_o
);

  localparam int unsigned Depth = QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  pt_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count beyond depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");

endmodule

// File: sv/shr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics rounding multiplier
// Computes a*v/2^30 with round half up; v is taken in two 27-bit digits, high digit first.
// ----------------------------------------------------------------------------
module shr_mul import shr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned LO_W = 27;
  localparam int unsigned HI_W = V_W - LO_W;
  localparam int unsigned P_W  = A_W + V_W;
  localparam logic signed [P_W-1:0] Rnd = P_W'(1) << (FRAC - 1);

  logic                         ph_q, done_q;
  logic signed [A_W-1:0]        a_q;
  logic [LO_W-1:0]              vl_q;
  logic signed [A_W+HI_W-1:0]   acc_q, hi_prod;
  logic signed [A_W+LO_W:0]     lo_prod;
  logic signed [P_W-1:0]        full_prod;
  logic signed [R_W-1:0]        res_q;

  assign hi_prod   = req_i.a * $signed(req_i.v[V_W-1:LO_W]);
  assign lo_prod   = a_q * $signed({1'b0, vl_q});
  assign full_prod = $signed({acc_q, {LO_W{1'b0}}}) + P_W'(lo_prod) + Rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= req_i.start;
      done_q <= ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= hi_prod;
      a_q   <= req_i.a;
      vl_q  <= req_i.v[LO_W-1:0];
    end
    if (ph_q) res_q <= full_prod[R_W+FRAC-1:FRAC];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !ph_q && !done_q) else $error("multiply started while busy");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> ##1 done_q) else $error("multiply result missing");

endmodule

// File: sv/shr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics sequencer
// Walks the zonal column, the diagonal and the column recurrences on the shared
// multiplier and drives the result register.
// ----------------------------------------------------------------------------
module shr_back import shr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  pt_t         pop_data_i,
  output mul_req_t    mul_req_o,
  input  mul_rsp_t    mul_rsp_i,
  shr_result_if.source result_o
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EMIT} state_e;
  typedef enum logic [1:0] {J_ONE, J_ZON, J_DIAG, J_COL} job_e;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic [2:0] st_q, st_d, l_q, l_d, m_q, m_d;
  pt_t    pt_q, pt_d;
  val_t   p1_q, p1_d, p2_q, p2_d, q1_q, q1_d, q2_q, q2_d, dp_q, dp_d, dm_q, dm_d;
  val_t   ev_q, ev_d;
  logic   elast_q, elast_d;
  logic signed [V_W-1:0] s_q, s_d;

  logic              ov_q, ov_d, olast_q, olast_d;
  logic [2:0]        odeg_q, odeg_d;
  logic signed [3:0] oord_q, oord_d;
  val_t              oval_q, oval_d;

  logic        half, is_diag, slot_free;
  logic [1:0]  sub;
  logic [5:0]  l6, m6;
  logic [11:0] kprod;
  logic [3:0]  c4;
  logic signed [A_W-1:0] x_a, y_a, z_a, r2_a, rcp_a;
  logic signed [R_W+4:0] cr;
  logic signed [R_W-1:0] nres;
  val_t        val;
  logic signed [3:0] ord;

  assign half    = (st_q >= 3'd3);
  assign is_diag = (job_q == J_DIAG);

  always_comb begin
    case (st_q)
      3'd0, 3'd3: sub = 2'd0;
      3'd1, 3'd4: sub = 2'd1;
      default:    sub = 2'd2;
    endcase
  end

  assign l6 = {3'b0, l_q};
  assign m6 = {3'b0, m_q};
  always_comb begin
    case (job_q)
      J_ZON:   kprod = 12'(l6 * l6);
      J_DIAG:  kprod = 12'({m6, 1'b0});
      J_COL:   kprod = 12'((l6 + m6) * (l6 - m6));
      default: kprod = '0;
    endcase
  end

  assign c4    = {l_q, 1'b0} - 4'd1;
  assign x_a   = A_W'(pt_q.x);
  assign y_a   = A_W'(pt_q.y);
  assign z_a   = A_W'(pt_q.z);
  assign r2_a  = $signed({{(A_W-R2_W){1'b0}}, pt_q.r2});
  assign rcp_a = $signed({{(A_W-RCP_W){1'b0}}, recip(kprod[5:0])});

  // operand routing for the current step
  always_comb begin
    mul_req_o.start = (state_q == S_ISSUE);
    mul_req_o.a     = rcp_a;
    mul_req_o.v     = s_q;
    case (sub)
      2'd0: begin
        if (is_diag) begin
          mul_req_o.a = half ? y_a : x_a;
          mul_req_o.v = V_W'(dp_q);
        end else begin
          mul_req_o.a = z_a;
          mul_req_o.v = half ? V_W'(q1_q) : V_W'(p1_q);
        end
      end
      2'd1: begin
        if (is_diag) begin
          mul_req_o.a = half ? x_a : y_a;
          mul_req_o.v = V_W'(dm_q);
        end else begin
          mul_req_o.a = r2_a;
          mul_req_o.v = half ? V_W'(q2_q) : V_W'(p2_q);
        end
      end
      default: begin
        mul_req_o.a = rcp_a;
        mul_req_o.v = s_q;
      end
    endcase
  end

  assign cr   = $signed({1'b0, c4}) * mul_rsp_i.res;
  assign nres = -mul_rsp_i.res;
  assign val  = is_diag ? sat_val(nres) : sat_val(mul_rsp_i.res);

  always_comb begin
    if (job_q == J_ONE || job_q == J_ZON) ord = 4'sd0;
    else if (half)                         ord = 4'(4'd0 - {1'b0, m_q});
    else                                   ord = {1'b0, m_q};
  end

  assign slot_free   = !ov_q || result_o.ready;
  assign pop_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; job_d = job_q; st_d = st_q; l_d = l_q; m_d = m_q;
    pt_d = pt_q; s_d = s_q; ev_d = ev_q; elast_d = elast_q;
    p1_d = p1_q; p2_d = p2_q; q1_d = q1_q; q2_d = q2_q; dp_d = dp_q; dm_d = dm_q;
    ov_d = ov_q; odeg_d = odeg_q; oord_d = oord_q; oval_d = oval_q; olast_d = olast_q;
    if (result_o.ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: if (pop_valid_i) begin
        pt_d    = pop_data_i;
        job_d   = J_ONE;
        st_d    = 3'd0;
        l_d     = 3'd0;
        m_d     = 3'd0;
        ev_d    = ONE_Q45;
        elast_d = (pop_data_i.top == 3'd0);
        p1_d    = ONE_Q45;
        p2_d    = '0;
        dp_d    = ONE_Q45;
        dm_d    = '0;
        state_d = S_EMIT;
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: if (mul_rsp_i.done) begin
        state_d = S_ISSUE;
        st_d    = st_q + 3'd1;
        case (sub)
          2'd0: s_d = is_diag ? mul_rsp_i.res[V_W-1:0] : cr[V_W-1:0];
          2'd1: begin
            if (is_diag && half) s_d = s_q + mul_rsp_i.res[V_W-1:0];
            else                 s_d = s_q - mul_rsp_i.res[V_W-1:0];
          end
          default: begin
            state_d = S_EMIT;
            st_d    = st_q;
            ev_d    = val;
            elast_d = is_diag && half && (m_q == pt_q.top);
            if (is_diag) begin
              if (half) begin
                dm_d = val;
                dp_d = p1_q;
                q1_d = val;
                p2_d = '0;
                q2_d = '0;
              end else begin
                p1_d = val;
              end
            end else if (half) begin
              q2_d = q1_q;
              q1_d = val;
            end else begin
              p2_d = p1_q;
              p1_d = val;
            end
          end
        endcase
      end
      S_EMIT: if (slot_free) begin
        ov_d    = 1'b1;
        odeg_d  = l_q;
        oord_d  = ord;
        oval_d  = ev_q;
        olast_d = elast_q;
        state_d = S_ISSUE;
        if (elast_q) begin
          state_d = S_IDLE;
        end else begin
          case (job_q)
            J_ONE: begin
              job_d = J_ZON;
              l_d   = 3'd1;
              st_d  = 3'd0;
            end
            J_ZON: begin
              st_d = 3'd0;
              if (l_q < pt_q.top) begin
                l_d = l_q + 3'd1;
              end else begin
                job_d = J_DIAG;
                l_d   = 3'd1;
                m_d   = 3'd1;
              end
            end
            J_DIAG: begin
              if (!half) begin
                st_d = 3'd3;
              end else begin
                job_d = J_COL;
                l_d   = m_q + 3'd1;
                st_d  = 3'd0;
              end
            end
            default: begin
              if (!half) begin
                st_d = 3'd3;
              end else begin
                st_d = 3'd0;
                if (l_q < pt_q.top) begin
                  l_d = l_q + 3'd1;
                end else begin
                  job_d = J_DIAG;
                  l_d   = m_q + 3'd1;
                  m_d   = m_q + 3'd1;
                end
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= J_ONE;
      st_q    <= 3'd0;
      l_q     <= 3'd0;
      m_q     <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      st_q    <= st_d;
      l_q     <= l_d;
      m_q     <= m_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q    <= pt_d;
    s_q     <= s_d;
    ev_q    <= ev_d;
    elast_q <= elast_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    q1_q    <= q1_d;
    q2_q    <= q2_d;
    dp_q    <= dp_d;
    dm_q    <= dm_d;
    odeg_q  <= odeg_d;
    oord_q  <= oord_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign result_o.valid          = ov_q;
  assign result_o.degree         = odeg_q;
  assign result_o.order          = oord_q;
  assign result_o.harmonic_value = oval_q;
  assign result_o.last           = olast_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> state_q == S_WAIT) else $error("product arrived outside wait");

endmodule

// File: sv/solid_harmonics_recurrence_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solid harmonics recurrence core
// Emits all unnormalized regular solid harmonics N+/N- of a point up to the
// configured degree, Q2.30 in and saturated Q3.45 out.
// ----------------------------------------------------------------------------
//  channel    dir  beat contents
//  point_i    in   coord_x, coord_y, coord_z
//  result_o   out  degree, order, harmonic_value, last
//  cfg        in   cfg_we_i / cfg_wdata_i = max_degree
//
//  A point yields (L+1)^2 beats; each beat after the first takes three
//  passes through the shared multiplier plus one emit.
//  r squared is formed in the front end, overlapped with the back.
//  Reset is asynchronous: max_degree returns to 7, queue and result empty.
//  A two-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
module solid_harmonics_recurrence_core import shr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = DEG_MAX
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  shr_point_if.sink     point_i,
  shr_result_if.source  result_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_wdata_i
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  pt_t      push_data, pop_data;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  shr_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_i      (point_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  shr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  shr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  shr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .result_o    (result_o)
  );

endmodule
